FILE: sv/assert_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CDFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CDFP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/cdfp_pkg.sv
package cdfp_pkg;

	// Scanner modes.
	typedef enum logic [1:0] {
		MODE_SKIP = 2'd0,
		MODE_INT  = 2'd1,
		MODE_FRAC = 2'd2,
		MODE_LINE = 2'd3
	} scan_mode_t;

	// Character codes the scanner reacts to.
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Saturation limit of the integer part.
	localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

	// Register map and reset values.
	localparam logic       REG_FIELDS_PER_LINE = 1'b0;
	localparam logic [3:0] FPL_RESET           = 4'd5;

	// One finished number.
	typedef struct packed {
		logic [63:0] value;
		logic [3:0]  index;
		logic        done;
	} result_t;

	// Handshake status of the scanner stage.
	typedef struct packed {
		logic busy;
		logic advance;
		logic emit;
	} scan_status_t;

endpackage

FILE: sv/csv_decimal_field_parser_core.sv
// A byte that ends a number passes through the input register and the scanner into the result register.
// Throughput: one byte per cycle while the input is not stalled; the scanner computes its next state combinationally.
// A full, stalled output register stalls the input only when a byte finishes a number.
// Reset (arst_n low) clears the scanner to skip mode, field count to zero,
// and fields_per_line to five.
`include "assert_macros.svh"

module csv_decimal_field_parser_core import cdfp_pkg::*; #(
	parameter int FRACTION_BITS       = 32,
	parameter int MAX_FRACTION_DIGITS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               text_valid,
	output logic               text_stall,
	input  logic [7:0]         text_byte,
	output logic               number_valid,
	input  logic               number_stall,
	output logic signed [63:0] number_value,
	output logic [3:0]         field_index,
	output logic               line_done
);

	logic [3:0]   fields_per_line;
	logic         out_free;
	result_t      result;
	scan_status_t status;
	logic [63:0]  value_raw;

	// Configuration register.
	cdfp_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.fields_per_line (fields_per_line)
	);

	// Input register and scanner.
	cdfp_scan #(
		.FRACTION_BITS       (FRACTION_BITS),
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_byte       (text_byte),
		.text_stall      (text_stall),
		.fields_per_line (fields_per_line),
		.out_free        (out_free),
		.result          (result),
		.status          (status)
	);

	// Result register.
	cdfp_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.result       (result),
		.out_free     (out_free),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.number_value (value_raw),
		.field_index  (field_index),
		.line_done    (line_done)
	);

	assign number_value = $signed(value_raw);

	// The input only stalls behind a full, stalled output register.
	`CDFP_ASSERT_IMPL(a_stall_cause, text_stall, number_valid && number_stall && status.busy, "input stalled without a blocked output")
	// A fresh result always comes from a word that finished a number.
	`CDFP_ASSERT_IMPL(a_new_result, $rose(number_valid), $past(status.advance && status.emit), "result appeared without a finished number")
	// A number not flagged as last leaves room in the line.
	`CDFP_ASSERT_IMPL(a_line_count, number_valid && !line_done && (fields_per_line != 4'd0), ({1'b0, field_index} + 5'd1) < {1'b0, fields_per_line}, "line count passed without line_done")

endmodule

FILE: sv/cdfp_regs.sv
module cdfp_regs import cdfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  fields_per_line
);

	logic [3:0] fpl_q;
	logic       wr_en;

	// The register takes a write in the access phase.
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpl_q <= FPL_RESET;
		end else if (wr_en && (paddr[2] == REG_FIELDS_PER_LINE)) begin
			fpl_q <= pwdata[3:0];
		end
	end

	// Read decode.
	always_comb begin
		unique case (paddr[2])
			REG_FIELDS_PER_LINE: prdata = {28'd0, fpl_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign fields_per_line = fpl_q;

endmodule

FILE: sv/cdfp_scan.sv
module cdfp_scan import cdfp_pkg::*; #(
	parameter int FRACTION_BITS       = 32,
	parameter int MAX_FRACTION_DIGITS = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	input  logic [7:0]   text_byte,
	output logic         text_stall,
	input  logic [3:0]   fields_per_line,
	input  logic         out_free,
	output result_t      result,
	output scan_status_t status
);

	localparam logic [63:0] ONE_FIX = 64'd1 << FRACTION_BITS;
	localparam int          FB4     = FRACTION_BITS + 4;

	// Weight of fraction digit k+1 is floor(2^FRACTION_BITS / 10^(k+1)).
	localparam logic [FRACTION_BITS-1:0] WEIGHT [9] = '{
		FRACTION_BITS'(ONE_FIX / 64'd10),
		FRACTION_BITS'(ONE_FIX / 64'd100),
		FRACTION_BITS'(ONE_FIX / 64'd1000),
		FRACTION_BITS'(ONE_FIX / 64'd10000),
		FRACTION_BITS'(ONE_FIX / 64'd100000),
		FRACTION_BITS'(ONE_FIX / 64'd1000000),
		FRACTION_BITS'(ONE_FIX / 64'd10000000),
		FRACTION_BITS'(ONE_FIX / 64'd100000000),
		FRACTION_BITS'(ONE_FIX / 64'd1000000000)
	};

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Scanner state.
	scan_mode_t               mode_q, mode_n;
	logic                     neg_q, neg_n;
	logic [30:0]              int_q, int_n;
	logic [FRACTION_BITS-1:0] frac_q, frac_n;
	logic [3:0]               cnt_q, cnt_n;
	logic [3:0]               fc_q, fc_n;

	// Byte classification.
	logic       is_digit, is_minus, is_dot, is_nl;
	logic [3:0] digit;

	// Datapath.
	logic [34:0]              int_wide;
	logic [30:0]              int_sat;
	logic [FRACTION_BITS-1:0] weight_sel;
	logic [FB4-1:0]           frac_prod;
	logic [FRACTION_BITS-1:0] frac_sum;
	logic                     frac_room;
	logic [63:0]              mag;
	logic                     by_count, line_end;
	logic [3:0]               fc_fin;
	scan_mode_t               start_mode;
	logic                     emit, advance;

	// The input register takes a new byte whenever it is empty or the scanner takes its word.
	assign text_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			byte_s1 <= text_byte;
		end
	end

	// Classify the byte under work.
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_minus = (byte_s1 == CHAR_MINUS);
	assign is_dot   = (byte_s1 == CHAR_DOT);
	assign is_nl    = (byte_s1 == CHAR_NEWLINE);
	assign digit    = byte_s1[3:0];

	always_comb begin
		if (is_minus || is_digit) begin
			start_mode = MODE_INT;
		end else if (is_dot) begin
			start_mode = MODE_FRAC;
		end else begin
			start_mode = MODE_SKIP;
		end
	end

	// Integer part: times ten plus digit, saturated.
	assign int_wide = 35'({int_q, 3'b000}) + 35'({int_q, 1'b0}) + 35'(digit);
	assign int_sat  = (int_wide > 35'(INT_MAX)) ? INT_MAX : int_wide[30:0];

	// Fraction part: one weighted digit per byte until the digit limit.
	assign frac_room  = cnt_q < 4'(MAX_FRACTION_DIGITS);
	assign weight_sel = frac_room ? WEIGHT[cnt_q] : '0;
	assign frac_prod  = FB4'(digit) * FB4'(weight_sel);
	assign frac_sum   = frac_q + frac_prod[FRACTION_BITS-1:0];

	// Finished value and line bookkeeping.
	assign mag = (64'(int_q) << FRACTION_BITS) + 64'(frac_q);
	assign by_count = (fields_per_line != 4'd0) &&
		(({1'b0, fc_q} + 5'd1) >= {1'b0, fields_per_line});
	assign line_end = is_nl || by_count;
	assign fc_fin   = line_end ? 4'd0 : fc_q + 4'd1;

	assign result.value = neg_q ? (64'd0 - mag) : mag;
	assign result.index = fc_q;
	assign result.done  = line_end;

	// Next state of the scanner.
	always_comb begin
		mode_n = mode_q;
		neg_n  = neg_q;
		int_n  = int_q;
		frac_n = frac_q;
		cnt_n  = cnt_q;
		fc_n   = fc_q;
		emit   = 1'b0;
		unique case (mode_q)
			MODE_SKIP: begin
				mode_n = start_mode;
				neg_n  = is_minus;
				int_n  = is_digit ? 31'(digit) : 31'd0;
				if (is_nl) begin
					fc_n = 4'd0;
				end
			end
			MODE_INT: begin
				if (is_digit) begin
					int_n = int_sat;
				end else if (is_dot) begin
					mode_n = MODE_FRAC;
				end else begin
					// The terminating byte is consumed with the number.
					emit   = 1'b1;
					fc_n   = fc_fin;
					mode_n = (by_count && !is_nl) ? MODE_LINE : MODE_SKIP;
					neg_n  = 1'b0;
					int_n  = 31'd0;
					frac_n = '0;
					cnt_n  = 4'd0;
				end
			end
			MODE_FRAC: begin
				if (is_digit) begin
					if (frac_room) begin
						frac_n = frac_sum;
						cnt_n  = cnt_q + 4'd1;
					end
				end else begin
					// The terminating byte also starts the next scan, unless the line's field count is reached.
					emit   = 1'b1;
					fc_n   = fc_fin;
					frac_n = '0;
					cnt_n  = 4'd0;
					if (by_count && !is_nl) begin
						mode_n = MODE_LINE;
						neg_n  = 1'b0;
						int_n  = 31'd0;
					end else begin
						mode_n = start_mode;
						neg_n  = is_minus;
						int_n  = is_digit ? 31'(digit) : 31'd0;
					end
				end
			end
			MODE_LINE: begin
				if (is_nl) begin
					mode_n = MODE_SKIP;
					fc_n   = 4'd0;
				end
			end
			default: begin
				mode_n = MODE_SKIP;
			end
		endcase
	end

	// A word with a result waits until the output register can take it.
	assign advance = valid_s1 && (out_free || !emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			neg_q  <= 1'b0;
			int_q  <= 31'd0;
			frac_q <= '0;
			cnt_q  <= 4'd0;
			fc_q   <= 4'd0;
		end else if (advance) begin
			mode_q <= mode_n;
			neg_q  <= neg_n;
			int_q  <= int_n;
			frac_q <= frac_n;
			cnt_q  <= cnt_n;
			fc_q   <= fc_n;
		end
	end

	assign status.busy    = valid_s1;
	assign status.advance = advance;
	assign status.emit    = emit;

endmodule

FILE: sv/cdfp_out.sv
module cdfp_out import cdfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  scan_status_t status,
	input  result_t      result,
	output logic         out_free,
	output logic         number_valid,
	input  logic         number_stall,
	output logic [63:0]  number_value,
	output logic [3:0]   field_index,
	output logic         line_done
);

	logic    valid_q;
	logic    load;
	result_t res_q;

	// The register can take a new word when empty or being drained.
	assign out_free = !valid_q || !number_stall;
	assign load     = status.advance && status.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!number_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign number_valid = valid_q;
	assign number_value = res_q.value;
	assign field_index  = res_q.index;
	assign line_done    = res_q.done;

endmodule
